// ===== src/rbps_pkg.sv =====
// ----------------------------------------------------------------------------
// rbps_pkg
// Shared types and constants of the best-peer selector: queue item layout,
// operation and candidate-change codes, sequencer states, datapath widths.
// ----------------------------------------------------------------------------
`default_nettype none

package rbps_pkg;

  localparam int ADDR_W = 48;
  localparam int LVL_W  = 16;
  localparam int RSSI_W = 8;

  // blend numerator and rounding dividend widths (weight denominator up to 64)
  localparam int NUM_W  = 26;
  localparam int DIVD_W = 24;
  // reciprocal width and shift, exact for dividends below 2**DIVD_W and
  // divisors up to 128
  localparam int RECIP_W  = 31;
  localparam int RECIP_SH = 31;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int ALPHA_W    = 4;
  localparam int HYST_W     = 5;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HYST  = 4'd1;

  typedef enum logic [0:0] {
    OP_OBSERVE = 1'b0,
    OP_CLEAR   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CHG_NONE    = 2'd0,
    CHG_SET     = 2'd1,
    CHG_REPLACE = 2'd2
  } chg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t                     op;
    logic [ADDR_W-1:0]       addr;
    logic signed [LVL_W-1:0] sample_q;
  } item_t;

endpackage

`default_nettype wire

// ===== src/rbps_ram.sv =====
// ----------------------------------------------------------------------------
// rbps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rbps_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/rbps_front.sv =====
// ----------------------------------------------------------------------------
// rbps_front
// Input side: accepts items, decodes the command, scales the sample to Q8.8
// and holds them in a two-entry queue for the lookup engine.
// ----------------------------------------------------------------------------
`default_nettype none

module rbps_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_cmd,
  input  wire logic [rbps_pkg::ADDR_W-1:0]    in_peer_addr,
  input  wire logic signed [rbps_pkg::RSSI_W-1:0] in_rssi,
  output logic                                q_valid,
  input  wire logic                           q_pop,
  output rbps_pkg::item_t                     q_item
);

  import rbps_pkg::*;

  item_t       slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  logic        pop;
  item_t       item_in;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = slot_r[rd_ptr_r];

  always_comb begin
    item_in.op       = in_cmd ? OP_CLEAR : OP_OBSERVE;
    item_in.addr     = in_peer_addr;
    item_in.sample_q = {in_rssi, 8'h00};
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

`default_nettype wire

// ===== src/rbps_back.sv =====
// ----------------------------------------------------------------------------
// rbps_back
// Lookup engine: scans the peer table, blends the level with a weighted
// multiply and a reciprocal multiply for the rounding division, updates the
// candidate and registers one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

module rbps_back #(
  parameter int TABLE_DEPTH = 16,
  parameter int ALPHA_DEN   = 10
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic [rbps_pkg::ALPHA_W-1:0]     alpha,
  input  wire logic [rbps_pkg::HYST_W-1:0]      hyst,
  input  wire logic                             q_valid,
  output logic                                  q_pop,
  input  wire rbps_pkg::item_t                  q_item,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [rbps_pkg::LVL_W-1:0]     out_smoothed_level,
  output logic                                  out_table_full,
  output logic                                  out_cand_valid,
  output logic [rbps_pkg::ADDR_W-1:0]           out_cand_addr,
  output logic signed [rbps_pkg::LVL_W-1:0]     out_cand_level,
  output logic [1:0]                            out_cand_change
);

  import rbps_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam int ENT_W = ADDR_W + LVL_W;
  localparam int PROD_W = DIVD_W + RECIP_W;
  localparam longint RND_DSR = 2 * ALPHA_DEN;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + RND_DSR - 1) / RND_DSR);

  state_t                  state_r, state_nxt;
  item_t                   item_r;
  logic [TABLE_DEPTH-1:0]  slot_used_r;

  logic                    issue_on_r;
  logic [IDX_W-1:0]        issue_idx_r;
  logic                    rd_vld_r;
  logic [IDX_W-1:0]        rd_idx_r;
  logic                    hit_r;
  logic [IDX_W-1:0]        hit_idx_r;
  logic signed [LVL_W-1:0] old_lvl_r;
  logic                    free_r;
  logic [IDX_W-1:0]        free_idx_r;

  logic signed [NUM_W-1:0] num_r;
  logic                    neg_r;
  logic [DIVD_W-1:0]       divd_r;
  logic [DIVD_W-1:0]       quo_r;
  logic signed [LVL_W-1:0] level_r;

  logic                    best_valid_r;
  logic [ADDR_W-1:0]       best_addr_r;
  logic signed [LVL_W-1:0] best_level_r;

  logic                    out_valid_r;
  logic signed [LVL_W-1:0] out_level_r;
  logic                    out_full_r;
  logic                    out_cvalid_r;
  logic [ADDR_W-1:0]       out_caddr_r;
  logic signed [LVL_W-1:0] out_clevel_r;
  chg_t                    out_change_r;

  // table memory
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [ENT_W-1:0]        ram_wdata;
  logic [ENT_W-1:0]        ram_rdata;

  rbps_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (issue_idx_r),
    .rdata (ram_rdata)
  );

  // scan compare
  logic hit_now;
  logic scan_end;
  assign hit_now  = rd_vld_r && !hit_r && slot_used_r[rd_idx_r] &&
                    (ram_rdata[ENT_W-1:LVL_W] == item_r.addr);
  assign scan_end = rd_vld_r && (rd_idx_r == LAST_IDX);

  // saturated weights
  logic [7:0]              a8;
  logic signed [NUM_W-1:0] wa;
  logic signed [NUM_W-1:0] wb;
  logic signed [NUM_W-1:0] num_nxt;
  logic [NUM_W-1:0]        mag;
  always_comb begin
    a8 = ({4'b0, alpha} > 8'(ALPHA_DEN)) ? 8'(ALPHA_DEN) : {4'b0, alpha};
    wa = NUM_W'($signed({1'b0, a8}));
    wb = NUM_W'($signed({1'b0, 8'(ALPHA_DEN) - a8}));
    num_nxt = NUM_W'(item_r.sample_q) * wa + NUM_W'(old_lvl_r) * wb;
    mag = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
  end

  // division by 2*ALPHA_DEN as a multiply by the rounded-up reciprocal
  logic [PROD_W-1:0] prod;
  always_comb begin
    prod = PROD_W'(divd_r) * PROD_W'(RECIP);
  end

  // sign restore and clamp
  logic signed [LVL_W-1:0] fix_lvl;
  always_comb begin
    if (neg_r) begin
      fix_lvl = (quo_r > DIVD_W'(32768)) ? 16'sh8000 : LVL_W'(-quo_r);
    end else begin
      fix_lvl = (quo_r > DIVD_W'(32767)) ? 16'sh7fff : LVL_W'(quo_r);
    end
  end

  // candidate decision
  logic                    entry_ok;
  logic [IDX_W-1:0]        wr_idx;
  logic signed [17:0]      lvl_ext;
  logic signed [17:0]      thr;
  logic                    nb_valid;
  logic [ADDR_W-1:0]       nb_addr;
  logic signed [LVL_W-1:0] nb_level;
  chg_t                    nb_change;
  always_comb begin
    entry_ok  = hit_r || free_r;
    wr_idx    = hit_r ? hit_idx_r : free_idx_r;
    lvl_ext   = 18'(level_r);
    thr       = 18'(best_level_r) + $signed({5'b0, hyst, 8'h00});
    nb_valid  = best_valid_r;
    nb_addr   = best_addr_r;
    nb_level  = best_level_r;
    nb_change = CHG_NONE;
    priority if (item_r.op == OP_CLEAR) begin
      nb_valid = 1'b0;
      nb_addr  = '0;
      nb_level = '0;
    end else if (!entry_ok) begin
      nb_change = CHG_NONE;
    end else if (!best_valid_r) begin
      nb_valid  = 1'b1;
      nb_addr   = item_r.addr;
      nb_level  = level_r;
      nb_change = CHG_SET;
    end else if ((best_addr_r != item_r.addr) && (lvl_ext >= thr)) begin
      nb_addr   = item_r.addr;
      nb_level  = level_r;
      nb_change = CHG_REPLACE;
    end
  end

  logic done_fire;
  assign done_fire = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_item.op == OP_CLEAR) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = (hit_r || hit_now) ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL:  state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_FIX;
      ST_FIX:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (done_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = wr_idx;
    ram_wdata = {item_r.addr, level_r};
    unique case (state_r)
      ST_IDLE: q_pop = q_valid;
      ST_DONE: ram_we = done_fire && (item_r.op == OP_OBSERVE) && entry_ok;
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_used_r  <= '0;
      best_valid_r <= 1'b0;
      best_addr_r  <= '0;
      best_level_r <= '0;
      out_valid_r  <= 1'b0;
      issue_on_r   <= 1'b0;
      rd_vld_r     <= 1'b0;
      hit_r        <= 1'b0;
      free_r       <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == ST_SCAN) && issue_on_r;
      if (state_r == ST_IDLE) begin
        issue_on_r <= 1'b1;
        hit_r      <= 1'b0;
        free_r     <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        if (issue_on_r) begin
          if (issue_idx_r == LAST_IDX) begin
            issue_on_r <= 1'b0;
          end
          if (!free_r && !slot_used_r[issue_idx_r]) begin
            free_r <= 1'b1;
          end
        end
        if (hit_now) begin
          hit_r <= 1'b1;
        end
      end
      if (done_fire) begin
        best_valid_r <= nb_valid;
        best_addr_r  <= nb_addr;
        best_level_r <= nb_level;
        if (item_r.op == OP_CLEAR) begin
          slot_used_r <= '0;
        end else if (entry_ok) begin
          slot_used_r[wr_idx] <= 1'b1;
        end
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
    if (state_r == ST_IDLE) begin
      issue_idx_r <= '0;
    end else if (state_r == ST_SCAN && issue_on_r) begin
      if (!free_r && !slot_used_r[issue_idx_r]) begin
        free_idx_r <= issue_idx_r;
      end
      if (issue_idx_r != LAST_IDX) begin
        issue_idx_r <= issue_idx_r + 1'b1;
      end
    end
    rd_idx_r <= issue_idx_r;
    if (hit_now) begin
      hit_idx_r <= rd_idx_r;
      old_lvl_r <= ram_rdata[LVL_W-1:0];
    end
    // a scan without a hit yields the new-entry level or zero for a full table
    if (state_r == ST_SCAN && scan_end && !(hit_r || hit_now)) begin
      level_r <= free_r ? item_r.sample_q : '0;
    end
    if (state_r == ST_IDLE && q_valid) begin
      level_r <= '0;
    end
    if (state_r == ST_MUL) begin
      num_r <= num_nxt;
    end
    if (state_r == ST_PREP) begin
      neg_r  <= num_r[NUM_W-1];
      divd_r <= DIVD_W'({mag, 1'b0}) + DIVD_W'(ALPHA_DEN);
    end
    if (state_r == ST_DIV) begin
      quo_r <= prod[RECIP_SH +: DIVD_W];
    end
    if (state_r == ST_FIX) begin
      level_r <= fix_lvl;
    end
    if (done_fire) begin
      out_level_r  <= (item_r.op == OP_OBSERVE && entry_ok) ? level_r : '0;
      out_full_r   <= (item_r.op == OP_OBSERVE) && !entry_ok;
      out_cvalid_r <= nb_valid;
      out_caddr_r  <= nb_valid ? nb_addr : '0;
      out_clevel_r <= nb_valid ? nb_level : '0;
      out_change_r <= nb_change;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_smoothed_level = out_level_r;
  assign out_table_full     = out_full_r;
  assign out_cand_valid     = out_cvalid_r;
  assign out_cand_addr      = out_caddr_r;
  assign out_cand_level     = out_clevel_r;
  assign out_cand_change    = out_change_r;

  a_mul_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> hit_r)
    else $error("blend started without a table hit");

  a_div_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |=> (state_r == ST_FIX))
    else $error("division did not finish in one cycle");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_full_r) |->
      (out_change_r == CHG_NONE && out_level_r == '0))
    else $error("full-table result carries a level or a candidate change");

  a_first_cand: assert property (@(posedge clk) disable iff (!rst_n)
    (done_fire && item_r.op == OP_OBSERVE && entry_ok && !best_valid_r) |=>
      (out_change_r == CHG_SET && best_valid_r))
    else $error("first stored peer did not become the candidate");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (done_fire && item_r.op == OP_CLEAR) |=>
      (!best_valid_r && slot_used_r == '0 && !out_cvalid_r))
    else $error("clear transaction left table or candidate state");

endmodule

`default_nettype wire

// ===== src/rssi_ewma_best_peer_selector.sv =====
// ----------------------------------------------------------------------------
// rssi_ewma_best_peer_selector
// Tracks a smoothed RSSI per peer in a small table and keeps one best peer
// with a hysteresis margin for replacement.
//
//   channel | direction | handshake          | payload
//   in_     | in        | in_valid/in_stall  | cmd, peer_addr, rssi
//   out_    | out       | out_valid/out_stall| smoothed_level, table_full, cand_*
//   cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// a clear transaction skips the table; a new peer or a full table takes the
// table scan only; a known peer takes the table scan (one entry per cycle
// through the table ram read port), then the blend multiply, the rounding
// division as a reciprocal multiply and a clamp step.
// a two-entry input queue keeps accepting until it is full while the engine
// works or a result waits under out_stall. reset is synchronous; the table
// valid bits clear at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module rssi_ewma_best_peer_selector #(
  parameter int TABLE_DEPTH = 16,
  parameter int ALPHA_DEN   = 10
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic                                   in_cmd,
  input  wire logic [rbps_pkg::ADDR_W-1:0]            in_peer_addr,
  input  wire logic signed [rbps_pkg::RSSI_W-1:0]     in_rssi,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [rbps_pkg::LVL_W-1:0]           out_smoothed_level,
  output logic                                        out_table_full,
  output logic                                        out_cand_valid,
  output logic [rbps_pkg::ADDR_W-1:0]                 out_cand_addr,
  output logic signed [rbps_pkg::LVL_W-1:0]           out_cand_level,
  output logic [1:0]                                  out_cand_change,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [rbps_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [rbps_pkg::CFG_DATA_W-1:0]        cfg_data
);

  import rbps_pkg::*;

  logic [ALPHA_W-1:0] alpha_r;
  logic [HYST_W-1:0]  hyst_r;
  logic               q_valid;
  logic               q_pop;
  item_t              q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_W'(3);
      hyst_r  <= HYST_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ALPHA) begin
        alpha_r <= cfg_data[ALPHA_W-1:0];
      end else if (cfg_index == REG_HYST) begin
        hyst_r <= cfg_data[HYST_W-1:0];
      end
    end
  end

  rbps_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_peer_addr (in_peer_addr),
    .in_rssi      (in_rssi),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_item       (q_item)
  );

  rbps_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ALPHA_DEN   (ALPHA_DEN)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .alpha              (alpha_r),
    .hyst               (hyst_r),
    .q_valid            (q_valid),
    .q_pop              (q_pop),
    .q_item             (q_item),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_smoothed_level (out_smoothed_level),
    .out_table_full     (out_table_full),
    .out_cand_valid     (out_cand_valid),
    .out_cand_addr      (out_cand_addr),
    .out_cand_level     (out_cand_level),
    .out_cand_change    (out_cand_change)
  );

endmodule

`default_nettype wire

// ===== tb/rssi_ewma_best_peer_selector_tb.sv =====
// ----------------------------------------------------------------------------
// rssi_ewma_best_peer_selector_tb
// Self-checking bench for the best-peer selector. Observe and clear
// transactions go in through a queue-fed driver. A peer table model computes
// the smoothed level and the candidate decision for each accepted
// transaction. The monitor checks every result field against that model.
// The run steps through several smoothing weights and hysteresis margins,
// with the extremes among them. It also varies the idling on both channels.
// ----------------------------------------------------------------------------

module rssi_ewma_best_peer_selector_tb;
  import rbps_pkg::*;

  localparam int PEER_SLOTS   = 16;
  localparam int WEIGHT_DEN   = 10;
  localparam int HOLD_CYCLES  = 200;
  localparam int QUIET_LIMIT  = 4000;
  localparam int END_SETTLE   = 60;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

  typedef struct {
    op_t                     op;
    logic [ADDR_W-1:0]       addr;
    logic signed [RSSI_W-1:0] rssi;
    bit                      drain_first;
  } peer_obs_t;

  typedef struct {
    logic signed [LVL_W-1:0] level;
    logic                    full;
    logic                    cand_valid;
    logic [ADDR_W-1:0]       cand_addr;
    logic signed [LVL_W-1:0] cand_level;
    chg_t                    change;
  } peer_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_cmd = 1'b0;
  logic [ADDR_W-1:0] in_peer_addr = '0;
  logic signed [RSSI_W-1:0] in_rssi = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [LVL_W-1:0] out_smoothed_level;
  logic out_table_full;
  logic out_cand_valid;
  logic [ADDR_W-1:0] out_cand_addr;
  logic signed [LVL_W-1:0] out_cand_level;
  logic [1:0] out_cand_change;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rssi_ewma_best_peer_selector #(
    .TABLE_DEPTH(PEER_SLOTS),
    .ALPHA_DEN(WEIGHT_DEN)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_peer_addr(in_peer_addr),
    .in_rssi(in_rssi),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_smoothed_level(out_smoothed_level),
    .out_table_full(out_table_full),
    .out_cand_valid(out_cand_valid),
    .out_cand_addr(out_cand_addr),
    .out_cand_level(out_cand_level),
    .out_cand_change(out_cand_change),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // peer table model and its configuration
  bit                      peer_used [PEER_SLOTS];
  logic [ADDR_W-1:0]       peer_addr_tab [PEER_SLOTS];
  logic signed [LVL_W-1:0] peer_level_tab [PEER_SLOTS];
  bit                      best_valid;
  logic [ADDR_W-1:0]       best_addr;
  logic signed [LVL_W-1:0] best_level;
  logic [ALPHA_W-1:0]      alpha_q = 4'd3;
  logic [HYST_W-1:0]       hyst_q = 5'd3;

  peer_obs_t    obs_pending [$];
  peer_result_t pending_results [$];
  logic [ADDR_W-1:0] peer_pool [$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  bit  in_took = 1'b0;
  int  n_queued = 0;
  int  n_in = 0;
  int  n_out = 0;
  int  n_full = 0;
  int  n_replace = 0;
  int  n_clear = 0;
  int  n_cfg = 0;
  int  mismatch_cnt = 0;
  int  quiet_cycles = 0;

  function automatic logic signed [LVL_W-1:0] blend_level(logic signed [LVL_W-1:0] sample_q,
                                                          logic signed [LVL_W-1:0] old_q);
    longint w;
    longint num;
    longint mag;
    longint q;
    w = alpha_q;
    if (w > WEIGHT_DEN) begin
      w = WEIGHT_DEN;
    end
    num = longint'(sample_q) * w + longint'(old_q) * (WEIGHT_DEN - w);
    mag = (num < 0) ? -num : num;
    // round half away from zero
    q = (2 * mag + WEIGHT_DEN) / (2 * WEIGHT_DEN);
    if (num < 0) begin
      q = -q;
    end
    if (q > 32767) begin
      q = 32767;
    end
    if (q < -32768) begin
      q = -32768;
    end
    return q[LVL_W-1:0];
  endfunction

  function automatic peer_result_t track_peer(peer_obs_t ob);
    peer_result_t r;
    int hit;
    int free_idx;
    logic signed [LVL_W-1:0] sample_q;
    logic signed [LVL_W-1:0] lvl;
    hit = -1;
    free_idx = -1;
    lvl = '0;
    sample_q = {ob.rssi, 8'h00};
    r.full = 1'b0;
    r.change = CHG_NONE;
    if (ob.op == OP_CLEAR) begin
      foreach (peer_used[i]) begin
        peer_used[i] = 1'b0;
      end
      best_valid = 1'b0;
      best_addr = '0;
      best_level = '0;
      n_clear++;
    end else begin
      for (int i = 0; i < PEER_SLOTS; i++) begin
        if (peer_used[i]) begin
          if (hit < 0 && peer_addr_tab[i] == ob.addr) begin
            hit = i;
          end
        end else if (free_idx < 0) begin
          free_idx = i;
        end
      end
      if (hit >= 0) begin
        lvl = blend_level(sample_q, peer_level_tab[hit]);
        peer_level_tab[hit] = lvl;
      end else if (free_idx >= 0) begin
        hit = free_idx;
        peer_used[hit] = 1'b1;
        peer_addr_tab[hit] = ob.addr;
        lvl = sample_q;
        peer_level_tab[hit] = lvl;
      end else begin
        r.full = 1'b1;
        n_full++;
      end
      if (hit >= 0) begin
        if (!best_valid) begin
          best_valid = 1'b1;
          best_addr = ob.addr;
          best_level = lvl;
          r.change = CHG_SET;
        end else if (best_addr != ob.addr &&
                     int'(lvl) >= int'(best_level) + int'(hyst_q) * 256) begin
          best_addr = ob.addr;
          best_level = lvl;
          r.change = CHG_REPLACE;
          n_replace++;
        end
      end
    end
    r.level = lvl;
    r.cand_valid = best_valid;
    r.cand_addr = best_valid ? best_addr : '0;
    r.cand_level = best_valid ? best_level : '0;
    return r;
  endfunction

  // driver: presents queued transactions, holds them while stalled
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      in_took = 1'b0;
      if (obs_pending.size() > 0 && obs_pending[0].drain_first &&
          pending_results.size() != 0) begin
        in_valid <= 1'b0;
      end else if (obs_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_cmd <= obs_pending[0].op;
        in_peer_addr <= obs_pending[0].addr;
        in_rssi <= obs_pending[0].rssi;
        in_valid <= 1'b1;
        void'(obs_pending.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor: checks results first, then records accepted input transactions
  always @(posedge clk) begin
    peer_result_t exp;
    peer_obs_t ob;
    if (rst_n && out_valid && !out_stall) begin
      n_out++;
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatch_cnt++;
      end else begin
        exp = pending_results.pop_front();
        if (out_smoothed_level !== exp.level) begin
          $error("smoothed_level: expected %0d, got %0d", exp.level, out_smoothed_level);
          mismatch_cnt++;
        end
        if (out_table_full !== exp.full) begin
          $error("table_full: expected %0d, got %0d", exp.full, out_table_full);
          mismatch_cnt++;
        end
        if (out_cand_valid !== exp.cand_valid) begin
          $error("cand_valid: expected %0d, got %0d", exp.cand_valid, out_cand_valid);
          mismatch_cnt++;
        end
        if (out_cand_addr !== exp.cand_addr) begin
          $error("cand_addr: expected %h, got %h", exp.cand_addr, out_cand_addr);
          mismatch_cnt++;
        end
        if (out_cand_level !== exp.cand_level) begin
          $error("cand_level: expected %0d, got %0d", exp.cand_level, out_cand_level);
          mismatch_cnt++;
        end
        if (out_cand_change !== exp.change) begin
          $error("cand_change: expected %0d, got %0d", exp.change, out_cand_change);
          mismatch_cnt++;
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      ob.op = op_t'(in_cmd);
      ob.addr = in_peer_addr;
      ob.rssi = in_rssi;
      ob.drain_first = 1'b0;
      pending_results.push_back(track_peer(ob));
      n_in++;
      in_took = 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[ADDR_W-1:0];
  endfunction

  task automatic queue_obs(op_t op, logic [ADDR_W-1:0] addr, logic signed [RSSI_W-1:0] rssi,
                           bit drain_first);
    peer_obs_t ob;
    ob.op = op;
    ob.addr = addr;
    ob.rssi = rssi;
    ob.drain_first = drain_first;
    obs_pending.push_back(ob);
    n_queued++;
  endtask

  // mostly a small set of recurring peers so the table fills, with stray
  // addresses and occasional clears mixed in
  task automatic queue_random(int count, int drain_at);
    int r;
    logic signed [RSSI_W-1:0] rssi;
    logic [ADDR_W-1:0] addr;
    peer_pool.delete();
    repeat ($urandom_range(22, 12)) peer_pool.push_back(rand_addr());
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      rssi = 8'($urandom_range(255));
      if ($urandom_range(99) < 12) begin
        case ($urandom_range(2))
          0: rssi = -8'sd128;
          1: rssi = -8'sd127;
          default: rssi = 8'sd127;
        endcase
      end
      addr = peer_pool[$urandom_range(peer_pool.size() - 1)];
      if (r < 3) begin
        queue_obs(OP_CLEAR, rand_addr(), rssi, i == drain_at);
      end else if (r < 9) begin
        queue_obs(OP_OBSERVE, rand_addr(), rssi, i == drain_at);
      end else begin
        queue_obs(OP_OBSERVE, addr, rssi, i == drain_at);
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (n_in != n_queued || pending_results.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ALPHA: alpha_q = val[ALPHA_W-1:0];
      REG_HYST:  hyst_q = val[HYST_W-1:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [ADDR_W-1:0] walk;
    int base;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 17;
    recv_idle_pct = 54;
    // extremes of address and sample, smoothing, same-peer report, takeover
    queue_obs(OP_OBSERVE, '0, -8'sd128, 1'b0);
    queue_obs(OP_OBSERVE, '0, 8'sd127, 1'b0);
    queue_obs(OP_OBSERVE, '1, 8'sd127, 1'b0);
    queue_obs(OP_OBSERVE, '1, -8'sd128, 1'b0);
    queue_obs(OP_OBSERVE, '0, 8'sd0, 1'b0);
    queue_obs(OP_OBSERVE, 48'h5555_5555_5555, -8'sd127, 1'b0);
    queue_obs(OP_CLEAR, 48'hAAAA_AAAA_AAAA, 8'sd5, 1'b0);
    // fill every slot, then one more peer finds the table full
    for (int k = 0; k < PEER_SLOTS; k++) begin
      walk = 48'h1 << (3 * k);
      queue_obs(OP_OBSERVE, walk, 8'(k * 9 - 70), 1'b0);
    end
    queue_obs(OP_OBSERVE, '1, 8'sd127, 1'b0);
    queue_obs(OP_CLEAR, '0, -8'sd1, 1'b0);
    wait_idle();

    write_reg(REG_ALPHA, 8'hF0);
    write_reg(REG_HYST, 8'hE0);
    write_reg(REG_UNUSED, 8'hA5);
    base = n_in;
    queue_random(300, -1);
    do @(posedge clk); while (n_in < base + 40);
    hold_req = 1'b1;
    wait_idle();

    send_idle_pct = 54;
    recv_idle_pct = 17;
    write_reg(REG_ALPHA, 8'h0A);
    write_reg(REG_HYST, 8'h1F);
    queue_random(300, 120);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_ALPHA, 8'h3F);
    write_reg(REG_HYST, 8'($urandom_range(255)));
    queue_random(150, -1);
    wait_idle();

    write_reg(REG_ALPHA, 8'($urandom_range(9, 1)));
    write_reg(REG_HYST, 8'($urandom_range(8)));
    queue_random(175, -1);
    wait_idle();

    repeat (END_SETTLE) @(posedge clk);
    $display("run covered %0d transactions in, %0d results checked, %0d register writes",
             n_in, n_out, n_cfg);
    $display("including %0d clears, %0d full-table rejects, %0d candidate takeovers",
             n_clear, n_full, n_replace);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
